/* src/hce_pkg.sv */
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, constants and helpers for the Hamiltonian cycle enumerator:
// sizes, item kinds, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int MaxVertices = 16;
  localparam int VtxW        = 5;
  localparam int RowW        = MaxVertices;
  localparam int AdjIdxW     = $clog2(MaxVertices);
  localparam int PathDepth   = MaxVertices + 1;
  localparam int KindW       = 2;
  localparam int CfgIdxW     = 2;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_FIND    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_START_VERTEX = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_LEVEL,
    S_FETCH,
    S_SCAN,
    S_CLOSE,
    S_EMIT,
    S_MISS
  } state_e;

  typedef struct packed {
    logic load;
    logic fresh;
    logic mark_done;
    logic seed;
    logic fetch_prev;
    logic fetch_cur;
    logic step;
    logic emit_init;
    logic emit;
    logic emit_nf;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic n_lt2;
    logic depth_ok;
    logic scan_end;
    logic pick_ok;
    logic last_level;
    logic close_ok;
    logic emit_end;
  } status_t;

  // Edge bit of one adjacency row towards vertex col; outside 1..MaxVertices reads 0
  function automatic logic edge_bit(input logic [RowW-1:0] row,
                                    input logic [VtxW-1:0] col);
    logic [VtxW-1:0] col_m1;
    logic            in_range;
    col_m1   = col - VtxW'(1);
    in_range = (col >= VtxW'(1)) && (col <= VtxW'(MaxVertices));
    return in_range ? row[col_m1[AdjIdxW-1:0]] : 1'b0;
  endfunction

endpackage

/* src/hce_ctrl.sv */
// ----------------------------------------------------------------------------
// hce_ctrl
// Search sequencer: accepts items, steps the depth-first search one level
// fetch or one candidate at a time, and sequences the result transfers.
// ----------------------------------------------------------------------------
module hce_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hce_pkg::KindW-1:0]       kind_i,
  input  hce_pkg::status_t                status_i,
  output hce_pkg::cmd_t                   cmd_o
);

  hce_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = start && (state_q == hce_pkg::S_IDLE);
  assign busy   = (state_q != hce_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hce_pkg::S_IDLE: begin
        if (accept && (kind_i == hce_pkg::KIND_FIND)) state_d = hce_pkg::S_ADV;
      end
      hce_pkg::S_ADV: begin
        if (status_i.done || status_i.n_lt2) state_d = hce_pkg::S_MISS;
        else state_d = hce_pkg::S_LEVEL;
      end
      hce_pkg::S_LEVEL: begin
        if (!status_i.depth_ok) state_d = hce_pkg::S_MISS;
        else state_d = hce_pkg::S_FETCH;
      end
      hce_pkg::S_FETCH: begin
        state_d = hce_pkg::S_SCAN;
      end
      hce_pkg::S_SCAN: begin
        if (status_i.scan_end) state_d = hce_pkg::S_LEVEL;
        else if (status_i.pick_ok) begin
          state_d = status_i.last_level ? hce_pkg::S_CLOSE : hce_pkg::S_LEVEL;
        end
      end
      hce_pkg::S_CLOSE: begin
        state_d = status_i.close_ok ? hce_pkg::S_EMIT : hce_pkg::S_LEVEL;
      end
      hce_pkg::S_EMIT: begin
        if (status_i.emit_end) state_d = hce_pkg::S_IDLE;
      end
      hce_pkg::S_MISS: begin
        state_d = hce_pkg::S_IDLE;
      end
      default: state_d = hce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      hce_pkg::S_IDLE: begin
        cmd_o.load  = accept && (kind_i == hce_pkg::KIND_LOAD);
        cmd_o.fresh = accept && (kind_i == hce_pkg::KIND_RESTART);
      end
      hce_pkg::S_ADV: begin
        cmd_o.mark_done = !status_i.done && status_i.n_lt2;
        cmd_o.seed      = !status_i.done && !status_i.n_lt2;
      end
      hce_pkg::S_LEVEL: begin
        cmd_o.mark_done  = !status_i.depth_ok;
        cmd_o.fetch_prev = status_i.depth_ok;
      end
      hce_pkg::S_FETCH: cmd_o.fetch_cur = 1'b1;
      hce_pkg::S_SCAN:  cmd_o.step      = 1'b1;
      hce_pkg::S_CLOSE: cmd_o.emit_init = status_i.close_ok;
      hce_pkg::S_EMIT:  cmd_o.emit      = 1'b1;
      hce_pkg::S_MISS:  cmd_o.emit_nf   = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hce_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/hce_datapath.sv */
// ----------------------------------------------------------------------------
// hce_datapath
// Adjacency rows, path stack, on-path mask, search pointers and the result
// register, updated under the controller's commands.
// ----------------------------------------------------------------------------
module hce_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hce_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [hce_pkg::VtxW-1:0]           cfg_data_i,
  input  logic [hce_pkg::VtxW-1:0]           row_index_i,
  input  logic [hce_pkg::RowW-1:0]           row_bits_i,
  input  hce_pkg::cmd_t                      cmd_i,
  output hce_pkg::status_t                   status_o,
  output logic                               valid_o,
  output logic [hce_pkg::VtxW-1:0]           vertex_o,
  output logic                               last_o,
  output logic                               found_o
);

  localparam logic [hce_pkg::VtxW-1:0] One  = hce_pkg::VtxW'(1);
  localparam logic [hce_pkg::VtxW-1:0] Two  = hce_pkg::VtxW'(2);
  localparam logic [hce_pkg::VtxW-1:0] MaxV = hce_pkg::VtxW'(hce_pkg::MaxVertices);

  logic [hce_pkg::VtxW-1:0] vcount_q, vcount_d;
  logic [hce_pkg::VtxW-1:0] startv_q, startv_d;
  logic [hce_pkg::RowW-1:0] adj_q [hce_pkg::MaxVertices];
  logic [hce_pkg::RowW-1:0] adj_d [hce_pkg::MaxVertices];
  logic [hce_pkg::VtxW-1:0] path_q [hce_pkg::PathDepth];
  logic [hce_pkg::VtxW-1:0] path_d [hce_pkg::PathDepth];
  logic [hce_pkg::VtxW-1:0] depth_q, depth_d;
  logic [hce_pkg::VtxW-1:0] prev_q, prev_d;
  logic [hce_pkg::VtxW-1:0] cand_q, cand_d;
  logic [hce_pkg::VtxW-1:0] idx_q, idx_d;
  logic [hce_pkg::RowW-1:0] on_path_q, on_path_d;
  logic                     done_q, done_d;
  logic                     valid_q, valid_d;
  logic [hce_pkg::VtxW-1:0] vertex_q, vertex_d;
  logic                     last_q, last_d;
  logic                     found_q, found_d;

  logic [hce_pkg::VtxW-1:0] n_eff;
  logic [hce_pkg::VtxW-1:0] cand_m1;
  logic                     cand_in;
  logic [hce_pkg::RowW-1:0] adj_row;
  logic [hce_pkg::VtxW-1:0] rd_addr;
  logic [hce_pkg::VtxW-1:0] rd_data;
  logic [hce_pkg::VtxW-1:0] rd_m1;
  logic [hce_pkg::VtxW-1:0] row_m1;
  logic [hce_pkg::VtxW-1:0] depth_p1;
  logic                     cfg_hit;
  logic                     fresh;

  assign n_eff    = (vcount_q > MaxV) ? MaxV : vcount_q;
  assign cand_m1  = cand_q - One;
  assign cand_in  = (cand_q >= One) && (cand_q <= MaxV);
  assign adj_row  = cand_in ? adj_q[cand_m1[hce_pkg::AdjIdxW-1:0]] : '0;
  assign row_m1   = row_index_i - One;
  assign depth_p1 = depth_q + One;

  assign status_o.done       = done_q;
  assign status_o.n_lt2      = (n_eff < Two);
  assign status_o.depth_ok   = (depth_q >= Two) && (depth_q <= n_eff);
  assign status_o.scan_end   = (cand_q > n_eff);
  assign status_o.pick_ok    = (cand_q <= n_eff) && cand_in
                               && hce_pkg::edge_bit(adj_row, prev_q)
                               && (cand_q != startv_q)
                               && !on_path_q[cand_m1[hce_pkg::AdjIdxW-1:0]];
  assign status_o.last_level = (depth_q == n_eff);
  assign status_o.close_ok   = hce_pkg::edge_bit(adj_row, startv_q);
  assign status_o.emit_end   = (idx_q == n_eff + One);

  always_comb begin
    if (cmd_i.fetch_prev) rd_addr = depth_q - One;
    else if (cmd_i.emit) rd_addr = status_o.emit_end ? One : idx_q;
    else rd_addr = depth_q;
  end

  assign rd_data = path_q[rd_addr];
  assign rd_m1   = rd_data - One;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == hce_pkg::CFG_VERTEX_COUNT)
                               || (cfg_index_i == hce_pkg::CFG_START_VERTEX));
  assign fresh   = cmd_i.fresh || cfg_hit;

  always_comb begin
    vcount_d  = vcount_q;
    startv_d  = startv_q;
    adj_d     = adj_q;
    path_d    = path_q;
    depth_d   = depth_q;
    prev_d    = prev_q;
    cand_d    = cand_q;
    idx_d     = idx_q;
    on_path_d = on_path_q;
    done_d    = done_q;
    valid_d   = 1'b0;
    vertex_d  = vertex_q;
    last_d    = last_q;
    found_d   = found_q;

    if (cfg_we_i && (cfg_index_i == hce_pkg::CFG_VERTEX_COUNT)) vcount_d = cfg_data_i;
    if (cfg_we_i && (cfg_index_i == hce_pkg::CFG_START_VERTEX)) startv_d = cfg_data_i;

    if (cmd_i.load && (row_index_i >= One) && (row_index_i <= MaxV)) begin
      adj_d[row_m1[hce_pkg::AdjIdxW-1:0]] = row_bits_i;
    end

    if (fresh) begin
      path_d    = '{default: '0};
      depth_d   = Two;
      on_path_d = '0;
      done_d    = 1'b0;
    end

    if (cmd_i.mark_done) begin
      done_d  = 1'b1;
      depth_d = One;
    end

    if (cmd_i.seed) path_d[1] = startv_q;

    if (cmd_i.fetch_prev) prev_d = rd_data;

    if (cmd_i.fetch_cur) begin
      if ((rd_data >= One) && (rd_data <= MaxV)) begin
        on_path_d[rd_m1[hce_pkg::AdjIdxW-1:0]] = 1'b0;
      end
      cand_d = rd_data + One;
    end

    if (cmd_i.step) begin
      if (status_o.scan_end) begin
        // drop back one level
        path_d[depth_q] = '0;
        depth_d         = depth_q - One;
      end else if (status_o.pick_ok) begin
        path_d[depth_q] = cand_q;
        on_path_d[cand_m1[hce_pkg::AdjIdxW-1:0]] = 1'b1;
        if (!status_o.last_level) begin
          depth_d          = depth_p1;
          path_d[depth_p1] = '0;
        end
      end else begin
        cand_d = cand_q + One;
      end
    end

    if (cmd_i.emit_init) idx_d = One;

    if (cmd_i.emit) begin
      valid_d  = 1'b1;
      vertex_d = rd_data;
      last_d   = status_o.emit_end;
      found_d  = 1'b1;
      idx_d    = idx_q + One;
    end

    if (cmd_i.emit_nf) begin
      valid_d  = 1'b1;
      vertex_d = '0;
      last_d   = 1'b1;
      found_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= hce_pkg::VtxW'(hce_pkg::MaxVertices);
      startv_q  <= One;
      adj_q     <= '{default: '0};
      path_q    <= '{default: '0};
      depth_q   <= Two;
      on_path_q <= '0;
      done_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      vcount_q  <= vcount_d;
      startv_q  <= startv_d;
      adj_q     <= adj_d;
      path_q    <= path_d;
      depth_q   <= depth_d;
      on_path_q <= on_path_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q   <= prev_d;
    cand_q   <= cand_d;
    idx_q    <= idx_d;
    vertex_q <= vertex_d;
    last_q   <= last_d;
    found_q  <= found_d;
  end

  assign valid_o  = valid_q;
  assign vertex_o = vertex_q;
  assign last_o   = last_q;
  assign found_o  = found_q;

endmodule

/* src/hamiltonian_cycle_enumerator.sv */
// ----------------------------------------------------------------------------
// hamiltonian_cycle_enumerator
// Depth-first enumeration of Hamiltonian cycles in a directed graph of up to
// sixteen vertices, resumed one cycle per find request.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Load-row and restart
// items complete in the cycle they are taken and give no result. A find
// request tests one candidate vertex per cycle against one adjacency row
// while scanning, fetches the previous and current path entries for each
// level visited and checks the closing edge of each full path; its length
// is data dependent, and an exhausted search goes straight to not-found.
// Results are then transferred on consecutive cycles, one per valid_o pulse,
// n + 1 for a cycle or one not-found result; the receiver cannot stall and
// must take each result in the cycle it is shown. Configuration writes are
// taken at any edge with cfg_we_i high, must be made while busy is low and no
// result is pending, and restart the search.
module hamiltonian_cycle_enumerator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hce_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hce_pkg::VtxW-1:0]      cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [hce_pkg::KindW-1:0]     kind_i,
  input  logic [hce_pkg::VtxW-1:0]      row_index_i,
  input  logic [hce_pkg::RowW-1:0]      row_bits_i,
  output logic                          valid_o,
  output logic [hce_pkg::VtxW-1:0]      vertex_o,
  output logic                          last_o,
  output logic                          found_o
);

  hce_pkg::cmd_t    cmd;
  hce_pkg::status_t status;

  hce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hce_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .valid_o     (valid_o),
    .vertex_o    (vertex_o),
    .last_o      (last_o),
    .found_o     (found_o)
  );

endmodule
